[hdl/per_bin_queue_depth_table_unit_assert.svh]
// assertion macros shared by the queue depth table
`ifndef PER_BIN_QUEUE_DEPTH_TABLE_UNIT_ASSERT_SVH
`define PER_BIN_QUEUE_DEPTH_TABLE_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PBQD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define PBQD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/pbqd_pkg.sv]
package pbqd_pkg;

  localparam int DEPTH_W = 32;
  localparam int DELTA_W = 33;
  localparam int BIN_W   = 5;
  localparam int CNT_W   = 6;
  localparam int ROW_W   = 2 * DEPTH_W;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

  typedef enum logic [1:0] {
    OP_ADJUST = 2'd0,
    OP_SET    = 2'd1,
    OP_GET    = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_SAT    = 2'd2,
    ST_FLOOR  = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

endpackage

[hdl/pbqd_ram.sv]
module pbqd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/per_bin_queue_depth_table_unit.sv]
// channel  | handshake          | payload
// ---------+--------------------+-------------------------------------------------
// in       | in_valid, in_stall | op, bin, delta, ls_delta, new_value, ls_class
// out      | out_valid, out_stall | read_depth, nonzero_count, status
//
// each item reads its row from the depth memory, then modifies it and writes it back
// the depth memory read is registered; clear-all passes through the same states
// reset clears one valid bit per row at once, so there is no clearing pass
// a waiting result does not block the next read; a stalled result holds the write-back
`include "per_bin_queue_depth_table_unit_assert.svh"

module per_bin_queue_depth_table_unit
  import pbqd_pkg::*;
#(
  parameter int BIN_COUNT = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                op,
  input  logic [BIN_W-1:0]          bin,
  input  logic signed [DELTA_W-1:0] delta,
  input  logic signed [DELTA_W-1:0] ls_delta,
  input  logic [DEPTH_W-1:0]        new_value,
  input  logic                      ls_class,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [DEPTH_W-1:0]        read_depth,
  output logic [CNT_W-1:0]          nonzero_count,
  output logic [1:0]                status
);

  localparam int AW = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
  localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'((BIN_COUNT > 32) ? 32 : BIN_COUNT);

  state_t state, state_next;

  logic               accept;
  logic               done;
  logic               clear_done;
  logic [8:0]         bin_ext;
  logic [AW-1:0]      addr;

  // captured item
  op_t                op_q;
  logic [AW-1:0]      addr_q;
  logic               in_range_q;
  logic [DELTA_W-1:0] delta_q;
  logic [DELTA_W-1:0] ls_delta_q;
  logic [DEPTH_W-1:0] new_value_q;
  logic               ls_class_q;

  logic [BIN_COUNT-1:0] row_valid;
  logic [CNT_W-1:0]     nz_count, nz_count_next;

  logic               wr_en;
  logic [ROW_W-1:0]   wr_data;
  logic [ROW_W-1:0]   rd_data;

  logic [DEPTH_W-1:0] cur, lcur, ov_new, ls_new, rd_val;
  logic [DELTA_W-1:0] dmag, lmag;
  logic [DEPTH_W+1:0] sum, lsum;
  logic               dneg, lneg, dnz, lnz;
  status_t            st_next;

  assign bin_ext    = 9'(bin);
  assign addr       = bin_ext[AW-1:0];
  assign accept     = in_valid && !in_stall;
  assign done       = (state == S_EXEC) && !(out_valid && out_stall);
  assign clear_done = done && (op_q == OP_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        in_stall = 1'b1;
        if (done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q        <= op_t'(op);
      addr_q      <= addr;
      in_range_q  <= bin_ext < 9'(BIN_COUNT);
      delta_q     <= $unsigned(delta);
      ls_delta_q  <= $unsigned(ls_delta);
      new_value_q <= new_value;
      ls_class_q  <= ls_class;
    end
  end

  pbqd_ram #(
    .WIDTH(ROW_W),
    .DEPTH(BIN_COUNT)
  ) u_depth_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(addr_q),
    .wr_data(wr_data),
    .rd_en  (accept),
    .rd_addr(addr),
    .rd_data(rd_data)
  );

  always_comb begin
    // a row never written since reset or clear reads as zero
    if (in_range_q && row_valid[addr_q]) begin
      cur  = rd_data[DEPTH_W-1:0];
      lcur = rd_data[ROW_W-1:DEPTH_W];
    end else begin
      cur  = '0;
      lcur = '0;
    end

    dneg = delta_q[DELTA_W-1];
    lneg = ls_delta_q[DELTA_W-1];
    dnz  = delta_q != '0;
    lnz  = ls_delta_q != '0;
    // the most negative value negates to 2^32, read as unsigned
    dmag = dneg ? (~delta_q + DELTA_W'(1)) : delta_q;
    lmag = lneg ? (~ls_delta_q + DELTA_W'(1)) : ls_delta_q;
    sum  = {2'b00, cur} + {1'b0, dmag};
    lsum = {2'b00, lcur} + {1'b0, lmag};

    ov_new  = cur;
    ls_new  = lcur;
    st_next = ST_OK;
    wr_en   = 1'b0;
    rd_val  = '0;

    case (op_q)
      OP_ADJUST: begin
        if (in_range_q && dnz) begin
          if ((lnz && (lneg != dneg)) || (lmag > dmag)) begin
            st_next = ST_REJECT;
          end else if (!dneg) begin
            if (sum[DEPTH_W+1:DEPTH_W] != 2'b00) begin
              ov_new  = DEPTH_MAX;
              st_next = ST_SAT;
            end else begin
              ov_new = sum[DEPTH_W-1:0];
              ls_new = (lsum[DEPTH_W+1:DEPTH_W] != 2'b00) ? DEPTH_MAX : lsum[DEPTH_W-1:0];
            end
            wr_en = done;
          end else begin
            if (dmag > {1'b0, cur}) begin
              ov_new  = '0;
              st_next = ST_FLOOR;
            end else begin
              ov_new = cur - dmag[DEPTH_W-1:0];
            end
            if (lmag > {1'b0, lcur}) begin
              ls_new  = '0;
              st_next = ST_FLOOR;
            end else begin
              ls_new = lcur - lmag[DEPTH_W-1:0];
            end
            wr_en = done;
          end
        end
      end
      OP_SET: begin
        if (in_range_q) begin
          if (ls_class_q) begin
            ls_new = new_value_q;
          end else begin
            ov_new = new_value_q;
          end
          wr_en = done;
        end
      end
      OP_GET: begin
        if (in_range_q) begin
          rd_val = ls_class_q ? lcur : cur;
        end
      end
      OP_CLEAR: begin
        ov_new = '0;
        ls_new = '0;
      end
      default: begin
        st_next = ST_OK;
      end
    endcase

    wr_data = {ls_new, ov_new};

    // the count follows the overall depth of the one row touched; clear-all zeroes it
    nz_count_next = nz_count;
    if (op_q == OP_CLEAR) begin
      nz_count_next = '0;
    end else if (wr_en) begin
      if ((cur == '0) && (ov_new != '0)) begin
        nz_count_next = nz_count + CNT_W'(1);
      end else if ((cur != '0) && (ov_new == '0)) begin
        nz_count_next = nz_count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      nz_count  <= '0;
    end else if (done) begin
      nz_count <= nz_count_next;
      if (op_q == OP_CLEAR) begin
        row_valid <= '0;
      end else if (wr_en) begin
        row_valid[addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      read_depth    <= rd_val;
      nonzero_count <= nz_count_next;
      status        <= st_next;
    end
  end

  `PBQD_ASSERT_NEXT(a_accept_exec, accept, state == S_EXEC, "item did not start")
  `PBQD_ASSERT_NOW(a_count_bound, 1'b1, nz_count <= CNT_CAP, "nonzero count above bin count")
  `PBQD_ASSERT_NOW(a_write_in_range, wr_en, in_range_q && done, "write to a bin out of range")
  `PBQD_ASSERT_NEXT(a_clear_count, clear_done, ~|{nz_count, nonzero_count}, "clear kept a count")

endmodule

[bench/depth_table_watch.sv]
module depth_table_watch
  import pbqd_pkg::*;
#(
  parameter int BIN_COUNT = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [1:0]          op,
  input  logic [BIN_W-1:0]    bin,
  input  logic [DELTA_W-1:0]  delta,
  input  logic [DELTA_W-1:0]  ls_delta,
  input  logic [DEPTH_W-1:0]  new_value,
  input  logic                ls_class,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [DEPTH_W-1:0]  read_depth,
  input  logic [CNT_W-1:0]    nonzero_count,
  input  logic [1:0]          status,
  output int                  fail_count,
  output int                  replies_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [CNT_W-1:0]   busy_bins;
    status_t            st;
  } depth_reply_t;

  logic [DEPTH_W-1:0] overall_tab [BIN_COUNT];
  logic [DEPTH_W-1:0] lat_tab [BIN_COUNT];
  depth_reply_t       depth_replies_q[$];

  initial begin
    fail_count   = 0;
    replies_owed = 0;
  end

  // sign of a 33-bit delta: -1, 0 or +1
  function automatic int delta_sign(logic [DELTA_W-1:0] d);
    if (d == '0) return 0;
    return d[DELTA_W-1] ? -1 : 1;
  endfunction

  // magnitude as unsigned 33 bits; the most negative value gives 2^32
  function automatic logic [DELTA_W-1:0] delta_mag(logic [DELTA_W-1:0] d);
    return d[DELTA_W-1] ? (~d + DELTA_W'(1)) : d;
  endfunction

  function automatic depth_reply_t next_depth_reply(op_t code, logic [BIN_W-1:0] b,
                                                    logic [DELTA_W-1:0] d,
                                                    logic [DELTA_W-1:0] l,
                                                    logic [DEPTH_W-1:0] val, logic cls);
    depth_reply_t       r;
    logic [DELTA_W-1:0] dm;
    logic [DELTA_W-1:0] lm;
    logic [DELTA_W:0]   sum;
    int                 ds;
    int                 lsg;
    int                 n;
    r.depth = '0;
    r.st    = ST_OK;
    ds  = delta_sign(d);
    lsg = delta_sign(l);
    dm  = delta_mag(d);
    lm  = delta_mag(l);
    if (code == OP_CLEAR) begin
      for (int i = 0; i < BIN_COUNT; i++) begin
        overall_tab[i] = '0;
        lat_tab[i]     = '0;
      end
    end else if (b < BIN_COUNT) begin
      case (code)
        OP_ADJUST: begin
          if (ds == 0) begin
            r.st = ST_OK;
          end else if ((lsg != 0 && lsg != ds) || lm > dm) begin
            r.st = ST_REJECT;
          end else if (ds > 0) begin
            sum = {2'b00, overall_tab[b]} + {1'b0, dm};
            if (sum > {2'b00, DEPTH_MAX}) begin
              // overall saturates, latency-sensitive left alone
              overall_tab[b] = DEPTH_MAX;
              r.st = ST_SAT;
            end else begin
              overall_tab[b] = sum[DEPTH_W-1:0];
              sum = {2'b00, lat_tab[b]} + {1'b0, lm};
              lat_tab[b] = (sum > {2'b00, DEPTH_MAX}) ? DEPTH_MAX : sum[DEPTH_W-1:0];
            end
          end else begin
            if (dm > {1'b0, overall_tab[b]}) begin
              overall_tab[b] = '0;
              r.st = ST_FLOOR;
            end else begin
              overall_tab[b] = overall_tab[b] - dm[DEPTH_W-1:0];
            end
            if (lm > {1'b0, lat_tab[b]}) begin
              lat_tab[b] = '0;
              r.st = ST_FLOOR;
            end else begin
              lat_tab[b] = lat_tab[b] - lm[DEPTH_W-1:0];
            end
          end
        end
        OP_SET: begin
          if (cls) lat_tab[b] = val;
          else overall_tab[b] = val;
        end
        OP_GET: begin
          r.depth = cls ? lat_tab[b] : overall_tab[b];
        end
        default: ;
      endcase
    end
    n = 0;
    for (int i = 0; i < BIN_COUNT; i++)
      if (overall_tab[i] != '0) n++;
    r.busy_bins = n[CNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    depth_reply_t want;
    if (rst) begin
      depth_replies_q.delete();
      for (int i = 0; i < BIN_COUNT; i++) begin
        overall_tab[i] = '0;
        lat_tab[i]     = '0;
      end
    end else begin
      // results first: none can belong to an item taken at this same edge
      if (out_valid && !out_stall) begin
        if (depth_replies_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result with no item pending: depth %h count %0d status %0d",
                     $realtime, read_depth, nonzero_count, status);
          fail_count++;
        end else begin
          want = depth_replies_q.pop_front();
          if (read_depth !== want.depth || nonzero_count !== want.busy_bins ||
              status !== want.st) begin
            if (fail_count < 10)
              $display("%0t: mismatch: depth %h/%h count %0d/%0d status %0d/%0d (exp/got)",
                       $realtime, want.depth, read_depth, want.busy_bins, nonzero_count,
                       want.st, status);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        depth_replies_q.push_back(next_depth_reply(op_t'(op), bin, delta, ls_delta,
                                                   new_value, ls_class));
    end
    replies_owed <= depth_replies_q.size();
  end

endmodule

[bench/tb.sv]
module tb
  import pbqd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BIN_COUNT   = 32;
  localparam int RAND_ITEMS  = 650;
  localparam int CYCLE_LIMIT = 200000;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [1:0]                op = OP_GET;
  logic [BIN_W-1:0]          bin = '0;
  logic signed [DELTA_W-1:0] delta = '0;
  logic signed [DELTA_W-1:0] ls_delta = '0;
  logic [DEPTH_W-1:0]        new_value = '0;
  logic                      ls_class = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [DEPTH_W-1:0]        read_depth;
  logic [CNT_W-1:0]          nonzero_count;
  logic [1:0]                status;

  int fail_count;
  int replies_owed;
  int tx_idle_pct = 13;
  int rx_idle_pct = 57;
  int cycle_count = 0;

  per_bin_queue_depth_table_unit #(.BIN_COUNT(BIN_COUNT)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .bin(bin), .delta(delta), .ls_delta(ls_delta),
    .new_value(new_value), .ls_class(ls_class),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_depth(read_depth), .nonzero_count(nonzero_count), .status(status)
  );

  depth_table_watch #(.BIN_COUNT(BIN_COUNT)) u_watch (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .bin(bin), .delta(delta), .ls_delta(ls_delta),
    .new_value(new_value), .ls_class(ls_class),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_depth(read_depth), .nonzero_count(nonzero_count), .status(status),
    .fail_count(fail_count), .replies_owed(replies_owed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    out_stall   <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_item(op_t code, logic [BIN_W-1:0] b, logic [DELTA_W-1:0] d,
                           logic [DELTA_W-1:0] l, logic [DEPTH_W-1:0] val, logic cls);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < tx_idle_pct) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    op        <= code;
    bin       <= b;
    delta     <= d;
    ls_delta  <= l;
    new_value <= val;
    ls_class  <= cls;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // directed items with small signed deltas
  task automatic send_small(op_t code, int b, int d, int l, logic [DEPTH_W-1:0] val,
                            logic cls);
    send_item(code, BIN_W'(b), DELTA_W'(d), DELTA_W'(l), val, cls);
  endtask

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [DELTA_W-1:0] rand_delta();
    return {1'($urandom_range(0, 1)), $urandom};
  endfunction

  // magnitude 0 .. 2^32, leaning to small values and the extremes
  function automatic logic [DELTA_W-1:0] pick_mag();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 33'd1;
      2: return 33'h1_0000_0000;
      3: return 33'h0_ffff_ffff;
      4: return {1'b0, $urandom};
      5, 6: return DELTA_W'($urandom_range(1, 255));
      default: return DELTA_W'($urandom_range(1, 1 << 20));
    endcase
  endfunction

  function automatic logic [DEPTH_W-1:0] pick_depth();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return DEPTH_MAX;
      2: return DEPTH_MAX - $urandom_range(0, 300);
      3: return $urandom;
      default: return $urandom_range(0, 1 << 20);
    endcase
  endfunction

  function automatic logic [BIN_W-1:0] pick_bin();
    if ($urandom_range(0, 9) < 7) return BIN_W'($urandom_range(0, 3));
    return BIN_W'($urandom_range(0, BIN_COUNT - 1));
  endfunction

  // same sign, latency-sensitive part no larger than the overall part
  task automatic send_clean_adjust();
    logic [DELTA_W-1:0] dm;
    logic [DELTA_W-1:0] lm;
    logic               neg;
    dm  = pick_mag();
    neg = rand_bit();
    if ($urandom_range(0, 3) == 0) lm = '0;
    else if (dm[DELTA_W-1]) lm = rand_bit() ? dm : {1'b0, $urandom};
    else lm = DELTA_W'($urandom_range(0, dm[DEPTH_W-1:0]));
    send_item(OP_ADJUST, pick_bin(), neg ? ~dm + DELTA_W'(1) : dm,
              neg ? ~lm + DELTA_W'(1) : lm, $urandom, rand_bit());
  endtask

  initial begin
    int pick;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_small(OP_GET,    0,  0,    0,    0, 1'b0);
    send_small(OP_ADJUST, 0,  0,    -7,   0, 1'b0);  // zero delta ignores ls_delta
    send_small(OP_ADJUST, 0,  100,  200,  0, 1'b0);  // ls magnitude too large
    send_small(OP_ADJUST, 0,  100,  -5,   0, 1'b0);  // signs differ
    send_small(OP_ADJUST, 0,  -100, 5,    0, 1'b0);
    send_small(OP_ADJUST, 0,  100,  0,    0, 1'b0);
    send_small(OP_ADJUST, 0,  -30,  0,    0, 1'b0);
    send_item(OP_ADJUST, 5'd31, 33'h0_ffff_ffff, 33'h0_ffff_ffff, 0, 1'b0);
    send_small(OP_ADJUST, 31, 1,    1,    0, 1'b0);  // overall saturates
    send_item(OP_ADJUST, 5'd31, 33'h1_0000_0000, 33'h1_0000_0000, 0, 1'b0);
    send_item(OP_ADJUST, 5'd1, 33'h1_0000_0000, 33'd5, 0, 1'b0);
    send_small(OP_SET,    5,  0,    0,    DEPTH_MAX, 1'b1);  // breaks table ordering
    send_small(OP_ADJUST, 5,  10,   10,   0, 1'b0);  // ls sum saturates quietly
    send_small(OP_GET,    5,  0,    0,    0, 1'b1);
    send_small(OP_ADJUST, 5,  -10,  -5,   0, 1'b0);
    send_small(OP_ADJUST, 5,  -1,   -1,   0, 1'b0);  // overall floors
    send_small(OP_SET,    7,  0,    0,    DEPTH_MAX, 1'b0);
    send_small(OP_GET,    7,  0,    0,    0, 1'b0);
    send_small(OP_GET,    0,  0,    0,    0, 1'b1);
    send_small(OP_CLEAR,  9,  0,    0,    0, 1'b0);
    send_small(OP_GET,    31, 0,    0,    0, 1'b0);
    send_small(OP_GET,    7,  0,    0,    0, 1'b0);
    send_small(OP_ADJUST, 2,  5,    5,    0, 1'b0);
    send_small(OP_ADJUST, 2,  -5,   -6,   0, 1'b0);

    // drain everything before the random part
    in_valid <= 1'b0;
    @(posedge clk);
    wait (replies_owed == 0);
    @(posedge clk);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS / 3) begin
        tx_idle_pct = 57;
        rx_idle_pct = 13;
      end else if (i == 2 * RAND_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 45)
        send_clean_adjust();
      else if (pick < 55)
        send_item(OP_ADJUST, pick_bin(), rand_delta(), rand_delta(), $urandom, rand_bit());
      else if (pick < 70)
        send_item(OP_SET, pick_bin(), rand_delta(), rand_delta(), pick_depth(), rand_bit());
      else if (pick < 97)
        send_item(OP_GET, pick_bin(), rand_delta(), rand_delta(), $urandom, rand_bit());
      else
        send_item(OP_CLEAR, BIN_W'($urandom_range(0, BIN_COUNT - 1)), rand_delta(),
                  rand_delta(), $urandom, rand_bit());
    end

    in_valid <= 1'b0;
    @(posedge clk);
    wait (replies_owed == 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && replies_owed == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
